>>> hw/rtl/spcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spcp_pkg;

    localparam int ID_IN_W  = 22;
    localparam int COL_W    = 23;
    localparam int ACC_W    = 32;
    localparam int ROW_W    = 40;
    localparam int NZ_W     = 48;
    localparam int FC_W     = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [32:0] MAP_ENTRIES_DEF = 33'd4194304;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DELIM   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_FIELD = 1'd1;

    localparam logic [7:0] DELIM_RST   = 8'd9;
    localparam logic [7:0] SAMPLES_RST = 8'd11;

    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic          CMD_TEXT  = 1'b0;
    localparam logic          CMD_MAPWR = 1'b1;

    localparam logic [FC_W-1:0]  FC_MAX  = 8'd255;
    localparam logic [ROW_W-1:0] ROW_MAX = 40'hff_ffff_ffff;
    localparam logic [NZ_W-1:0]  NZ_MAX  = 48'hffff_ffff_ffff;
    localparam logic [ACC_W-1:0] ACC_MAX = 32'hffff_ffff;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         data_byte;
        logic [ID_IN_W-1:0] map_sample_id;
        logic [COL_W-1:0]   map_column;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0] row_number;
        logic [COL_W-1:0] column_number;
        logic [ACC_W-1:0] pair_count;
        logic             id_beyond_map;
        logic [NZ_W-1:0]  nonzero_total;
    } t_out_item;

    typedef struct packed {
        logic             is_write;
        logic [ACC_W-1:0] id;
        logic [COL_W-1:0] wcol;
        logic [ROW_W-1:0] row;
        logic [ACC_W-1:0] count;
        logic [NZ_W-1:0]  total;
    } t_q_entry;

    function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [7:0] ch);
        logic [ACC_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {(ACC_W)'(0), ch[3:0]};
        acc_digit = (v > {4'b0000, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/spcp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module spcp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire spcp_pkg::t_q_entry  i_entry,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output spcp_pkg::t_q_entry       o_head
);
    localparam int DEPTH = spcp_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    spcp_pkg::t_q_entry r_slot [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/spcp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module spcp_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [spcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [spcp_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire spcp_pkg::t_in_item                  i_item,
    input  wire logic                                i_clearing,
    input  wire logic                                i_q_full,
    output logic                                     o_push,
    output spcp_pkg::t_q_entry                       o_entry
);
    logic [7:0] r_delim, r_samples;
    logic [spcp_pkg::FC_W-1:0]  r_fc, n_fc;
    logic                       r_in_pair, n_in_pair;
    logic [1:0]                 r_fcc, n_fcc;
    logic                       r_in_count, n_in_count;
    logic [spcp_pkg::ACC_W-1:0] r_id, n_id;
    logic                       r_id_done, n_id_done;
    logic [spcp_pkg::ACC_W-1:0] r_cnt, n_cnt;
    logic                       r_cnt_done, n_cnt_done;
    logic [spcp_pkg::ROW_W-1:0] r_row, n_row;
    logic [spcp_pkg::NZ_W-1:0]  r_nz, n_nz;

    logic                       accept, emit, clr_pair, digit;
    logic [7:0]                 ch;
    logic [spcp_pkg::FC_W-1:0]  fc_inc;
    logic [spcp_pkg::ROW_W-1:0] row_p1, emit_row;
    logic [spcp_pkg::NZ_W-1:0]  nz_p1;

    assign o_ready = !i_clearing && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign ch      = i_item.data_byte;
    assign digit   = ch inside {[spcp_pkg::CH_ZERO:spcp_pkg::CH_NINE]};
    assign fc_inc  = (r_fc != spcp_pkg::FC_MAX) ? r_fc + 8'd1 : r_fc;
    assign row_p1  = (r_row != spcp_pkg::ROW_MAX) ? r_row + 40'd1 : r_row;
    assign nz_p1   = (r_nz != spcp_pkg::NZ_MAX) ? r_nz + 48'd1 : r_nz;

    always_comb begin
        n_fc       = r_fc;
        n_in_pair  = r_in_pair;
        n_fcc      = r_fcc;
        n_in_count = r_in_count;
        n_id       = r_id;
        n_id_done  = r_id_done;
        n_cnt      = r_cnt;
        n_cnt_done = r_cnt_done;
        n_row      = r_row;
        n_nz       = r_nz;
        emit       = 1'b0;
        clr_pair   = 1'b0;
        emit_row   = row_p1;
        if (accept && i_item.cmd == spcp_pkg::CMD_TEXT) begin
            if (ch == r_delim) begin
                if (r_in_pair && r_fcc != 2'd0) begin
                    emit = 1'b1;
                end
                n_in_pair = 1'b0;
                n_fc      = fc_inc;
                if (fc_inc != r_fc && fc_inc == r_samples) begin
                    n_in_pair = 1'b1;
                    n_fcc     = 2'd0;
                    clr_pair  = 1'b1;
                end
            end else if (ch == spcp_pkg::CH_NEWLINE) begin
                n_row    = row_p1;
                emit     = r_in_pair && r_fcc != 2'd0;
                n_in_pair = 1'b0;
                n_fcc    = 2'd0;
                n_fc     = 8'd1;
                clr_pair = 1'b1;
            end else if (r_in_pair) begin
                if (r_fcc == 2'd0) begin
                    n_fcc = 2'd1;
                end else begin
                    n_fcc = 2'd2;
                    if (ch == spcp_pkg::CH_COMMA) begin
                        emit = 1'b1;
                    end else if (ch == spcp_pkg::CH_COLON) begin
                        n_in_count = 1'b1;
                        n_id_done  = 1'b1;
                        n_cnt      = '0;
                        n_cnt_done = 1'b0;
                    end else if (!r_in_count) begin
                        if (digit && !r_id_done) begin
                            n_id = spcp_pkg::acc_digit(r_id, ch);
                        end else begin
                            n_id_done = 1'b1;
                        end
                    end else begin
                        if (digit && !r_cnt_done) begin
                            n_cnt = spcp_pkg::acc_digit(r_cnt, ch);
                        end else begin
                            n_cnt_done = 1'b1;
                        end
                    end
                end
            end
        end
        if (emit) begin
            n_nz     = nz_p1;
            clr_pair = 1'b1;
        end
        if (clr_pair) begin
            n_in_count = 1'b0;
            n_id       = '0;
            n_id_done  = 1'b0;
            n_cnt      = '0;
            n_cnt_done = 1'b0;
        end
    end

    always_comb begin
        o_push           = accept && (i_item.cmd == spcp_pkg::CMD_MAPWR || emit);
        o_entry.is_write = (i_item.cmd == spcp_pkg::CMD_MAPWR);
        o_entry.wcol     = i_item.map_column;
        o_entry.id       = (i_item.cmd == spcp_pkg::CMD_MAPWR)
                         ? {10'd0, i_item.map_sample_id} : r_id;
        o_entry.row      = emit_row;
        o_entry.count    = r_in_count ? r_cnt : '0;
        o_entry.total    = nz_p1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim    <= spcp_pkg::DELIM_RST;
            r_samples  <= spcp_pkg::SAMPLES_RST;
            r_fc       <= 8'd1;
            r_in_pair  <= 1'b0;
            r_fcc      <= 2'd0;
            r_in_count <= 1'b0;
            r_id       <= '0;
            r_id_done  <= 1'b0;
            r_cnt      <= '0;
            r_cnt_done <= 1'b0;
            r_row      <= '0;
            r_nz       <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == spcp_pkg::CFG_FIELD_DELIM) begin
                r_delim <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == spcp_pkg::CFG_SAMPLES_FIELD) begin
                r_samples <= i_cfg_data;
            end
            r_fc       <= n_fc;
            r_in_pair  <= n_in_pair;
            r_fcc      <= n_fcc;
            r_in_count <= n_in_count;
            r_id       <= n_id;
            r_id_done  <= n_id_done;
            r_cnt      <= n_cnt;
            r_cnt_done <= n_cnt_done;
            r_row      <= n_row;
            r_nz       <= n_nz;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/spcp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module spcp_back #(
    parameter logic [32:0] MAP_ENTRIES = spcp_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_empty,
    input  wire spcp_pkg::t_q_entry  i_head,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output spcp_pkg::t_out_item      o_item
);
    localparam int AW = $clog2(MAP_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_ENTRIES - 33'd1);

    logic [spcp_pkg::COL_W-1:0] r_map [MAP_ENTRIES];

    logic                       r_clearing;
    logic [AW-1:0]              r_clr_addr;
    logic [spcp_pkg::COL_W-1:0] r_rd_col;
    logic                       r_s1_valid;
    spcp_pkg::t_out_item        r_s1_meta;
    logic                       r_out_valid;
    spcp_pkg::t_out_item        r_out_item;

    logic                       out_free, s1_adv, s1_free, beyond, rd_en, wr_en;
    logic [AW-1:0]              wr_addr;
    logic [spcp_pkg::COL_W-1:0] wr_data;

    assign beyond   = ({1'b0, i_head.id} >= MAP_ENTRIES);
    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign o_pop    = !r_clearing && !i_q_empty && (i_head.is_write || s1_free);
    assign rd_en    = o_pop && !i_head.is_write;
    assign wr_en    = r_clearing || (o_pop && i_head.is_write && !beyond);
    assign wr_addr  = r_clearing ? r_clr_addr : i_head.id[AW-1:0];
    assign wr_data  = r_clearing ? '0 : i_head.wcol;

    assign o_clearing = r_clearing;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out_item;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_col <= r_map[i_head.id[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_meta.row_number    <= i_head.row;
            r_s1_meta.column_number <= '0;
            r_s1_meta.pair_count    <= i_head.count;
            r_s1_meta.id_beyond_map <= beyond;
            r_s1_meta.nonzero_total <= i_head.total;
        end
        if (s1_adv) begin
            r_out_item.row_number    <= r_s1_meta.row_number;
            r_out_item.column_number <= r_s1_meta.id_beyond_map ? '0 : r_rd_col;
            r_out_item.pair_count    <= r_s1_meta.pair_count;
            r_out_item.id_beyond_map <= r_s1_meta.id_beyond_map;
            r_out_item.nonzero_total <= r_s1_meta.nonzero_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            if (rd_en) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/sparse_pair_column_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Parses a text byte stream one request per clock while o_in_ready is high: a front end
// tracks fields, lines and id:count pairs and posts each finished pair (and each map
// write) into a four-entry queue; a back end looks the id up in the on-chip column map
// and drives the result register. Sustained rate is one request per cycle unless the
// queue fills under output back-pressure; a result passes through the queue, the map
// read register and the output register. After reset the map is swept to zero, one
// entry a cycle, during which o_in_ready stays low; configuration writes are for the
// user to make only while the block is idle, which the block itself does not enforce.
module sparse_pair_column_parser #(
    parameter logic [32:0] MAP_ENTRIES = spcp_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [spcp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [spcp_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire spcp_pkg::t_in_item               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output spcp_pkg::t_out_item                   o_out_data
);
    logic               clearing, q_full, q_empty, q_push, q_pop;
    spcp_pkg::t_q_entry q_in, q_head;

    spcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_data),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    spcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    spcp_back #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_data)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_out_valid && q_empty)
        else $error("result or queued request during map clear");

    a_total_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> !o_out_valid
            || o_out_data.nonzero_total != $past(o_out_data.nonzero_total)
            || $past(o_out_data.nonzero_total) == spcp_pkg::NZ_MAX)
        else $error("pair total did not advance between results");

    a_pop_only_when_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");
`endif
endmodule
`default_nettype wire
